// ===== hdl/spc_pkg.sv =====
// Shared types, constants and CORDIC tables for the scan polar-to-Cartesian converter.
`timescale 1ns / 1ps

package spc_pkg;

   // Item field widths
   localparam int BEAM_BITS  = 11;
   localparam int RSAMP_BITS = 16;
   localparam int POS_BITS   = 17;

   // Configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_ANGLE = 3'd0,
      CSR_STEP_ANGLE  = 3'd1,
      CSR_NUM_STEPS   = 3'd2,
      CSR_MAX_RANGE   = 3'd3
   } spc_csr_type;

   typedef struct packed {
      logic [15:0]        start_angle;
      logic signed [15:0] step_angle;
      logic [11:0]        num_steps;
      logic [15:0]        max_range;
   } spc_cfg_type;

   // Flags that travel alongside each item down the pipe
   typedef struct packed {
      logic flip;
      logic clamped;
      logic index_error;
   } spc_tag_type;

   // CORDIC
   localparam int CORDIC_ITERS = 28;
   localparam int Z_BITS       = 34;
   localparam int GAIN_BITS    = 30;
   localparam logic [GAIN_BITS-1:0] GAIN_INV_Q30 = 30'd652032874;

   // atan(2^-i) in 2^32 units per turn
   localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5
   };

endpackage

// ===== hdl/spc_req_if.sv =====
// Input channel: beam index and range sample with valid/ready.
`timescale 1ns / 1ps

interface spc_req_if;
   logic                           valid;
   logic                           ready;
   logic [spc_pkg::BEAM_BITS-1:0]  beam_index;
   logic [spc_pkg::RSAMP_BITS-1:0] range_sample;

   modport source (output valid, output beam_index, output range_sample, input ready);
   modport sink   (input valid, input beam_index, input range_sample, output ready);
endinterface

// ===== hdl/spc_rsp_if.sv =====
// Result channel: Cartesian point and status flags with valid/ready.
`timescale 1ns / 1ps

interface spc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spc_pkg::POS_BITS-1:0] x_pos;
   logic signed [spc_pkg::POS_BITS-1:0] y_pos;
   logic                                clamped;
   logic                                index_error;

   modport source (output valid, output x_pos, output y_pos, output clamped,
                   output index_error, input ready);
   modport sink   (input valid, input x_pos, input y_pos, input clamped,
                   input index_error, output ready);
endinterface

// ===== hdl/spc_front.sv =====
// Front end: beam angle, range clamp, quadrant fold and gain-scaled start vector.
`timescale 1ns / 1ps

module spc_front #(
   parameter int MAX_BEAMS  = 2048,
   parameter int ANGLE_BITS = 16,
   parameter int RANGE_BITS = 16,
   localparam int DW        = RANGE_BITS + 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spc_pkg::spc_cfg_type                cfg,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic [spc_pkg::BEAM_BITS-1:0]       beam_index,
   input  logic [spc_pkg::RSAMP_BITS-1:0]      range_sample,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output logic signed [DW-1:0]                dn_x,
   output logic signed [spc_pkg::Z_BITS-1:0]   dn_z,
   output logic [RANGE_BITS-1:0]               dn_r,
   output spc_pkg::spc_tag_type                dn_tag
);
   import spc_pkg::*;

   localparam logic [16:0] MAXB = 17'(MAX_BEAMS);

   // stage A: angle and clamp
   logic [16:0]            beams;
   logic [31:0]            rs_wide;
   logic [RANGE_BITS-1:0]  r_raw;
   logic signed [28:0]     prod_a;
   logic [47:0]            sum_a;
   logic                   ready_a;
   logic                   valid_a_ff, valid_a_in;
   logic [RANGE_BITS-1:0]  r_a_ff, r_a_in;
   logic [ANGLE_BITS-1:0]  ang_a_ff, ang_a_in;
   spc_tag_type            tag_a_ff, tag_a_in;

   // stage B: fold and start vector
   logic [31:0]                   a32_b;
   logic [31:0]                   a32_fold;
   logic                          flip_b;
   logic [RANGE_BITS+GAIN_BITS-1:0] prod_b;
   logic                          ready_b;
   logic                          valid_b_ff, valid_b_in;
   logic signed [DW-1:0]          x_b_ff, x_b_in;
   logic signed [Z_BITS-1:0]      z_b_ff, z_b_in;
   logic [RANGE_BITS-1:0]         r_b_ff, r_b_in;
   spc_tag_type                   tag_b_ff, tag_b_in;

   assign ready_a  = !valid_a_ff || ready_b;
   assign ready_b  = !valid_b_ff || dn_ready;
   assign up_ready = ready_a;

   // effective beam count: zero acts as one, capped at MAX_BEAMS
   always_comb begin
      if (cfg.num_steps == 12'd0) begin
         beams = 17'd1;
      end else if (17'(cfg.num_steps) > MAXB) begin
         beams = MAXB;
      end else begin
         beams = 17'(cfg.num_steps);
      end
   end

   assign rs_wide = 32'(range_sample);
   assign r_raw   = rs_wide[RANGE_BITS-1:0];
   assign prod_a  = $signed({1'b0, beam_index}) * cfg.step_angle;
   assign sum_a   = 48'(cfg.start_angle) + 48'(prod_a);

   always_comb begin
      valid_a_in = valid_a_ff;
      r_a_in     = r_a_ff;
      ang_a_in   = ang_a_ff;
      tag_a_in   = tag_a_ff;
      if (ready_a) begin
         valid_a_in           = up_valid;
         ang_a_in             = sum_a[ANGLE_BITS-1:0];
         tag_a_in.flip        = 1'b0;
         tag_a_in.index_error = (17'(beam_index) >= beams);
         if (33'(r_raw) > 33'(cfg.max_range)) begin
            r_a_in           = RANGE_BITS'(cfg.max_range);
            tag_a_in.clamped = 1'b1;
         end else begin
            r_a_in           = r_raw;
            tag_a_in.clamped = 1'b0;
         end
      end
   end

   // fold the second and third quadrants by half a turn
   assign a32_b    = 32'(ang_a_ff) << (32 - ANGLE_BITS);
   assign flip_b   = a32_b[31] ^ a32_b[30];
   assign a32_fold = {a32_b[31] ^ flip_b, a32_b[30:0]};
   assign prod_b   = r_a_ff * GAIN_INV_Q30;

   always_comb begin
      valid_b_in = valid_b_ff;
      x_b_in     = x_b_ff;
      z_b_in     = z_b_ff;
      r_b_in     = r_b_ff;
      tag_b_in   = tag_b_ff;
      if (ready_b) begin
         valid_b_in    = valid_a_ff;
         x_b_in        = DW'(prod_b);
         z_b_in        = Z_BITS'($signed(a32_fold));
         r_b_in        = r_a_ff;
         tag_b_in      = tag_a_ff;
         tag_b_in.flip = flip_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
      r_a_ff   <= r_a_in;
      ang_a_ff <= ang_a_in;
      tag_a_ff <= tag_a_in;
      x_b_ff   <= x_b_in;
      z_b_ff   <= z_b_in;
      r_b_ff   <= r_b_in;
      tag_b_ff <= tag_b_in;
   end

   assign dn_valid = valid_b_ff;
   assign dn_x     = x_b_ff;
   assign dn_z     = z_b_ff;
   assign dn_r     = r_b_ff;
   assign dn_tag   = tag_b_ff;

endmodule

// ===== hdl/spc_cell.sv =====
// One CORDIC rotation cell: a fixed shift and angle constant, registered toward its neighbor.
`timescale 1ns / 1ps

module spc_cell #(
   parameter int STAGE      = 0,
   parameter int RANGE_BITS = 16,
   localparam int DW        = RANGE_BITS + 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic signed [DW-1:0]              up_x,
   input  logic signed [DW-1:0]              up_y,
   input  logic signed [spc_pkg::Z_BITS-1:0] up_z,
   input  logic [RANGE_BITS-1:0]             up_r,
   input  spc_pkg::spc_tag_type              up_tag,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic signed [DW-1:0]              dn_x,
   output logic signed [DW-1:0]              dn_y,
   output logic signed [spc_pkg::Z_BITS-1:0] dn_z,
   output logic [RANGE_BITS-1:0]             dn_r,
   output spc_pkg::spc_tag_type              dn_tag
);
   import spc_pkg::*;

   localparam logic signed [Z_BITS-1:0] TURN = Z_BITS'(ATAN_TURN[STAGE]);

   logic signed [DW-1:0]     dx, dy;
   logic                     valid_ff, valid_in;
   logic signed [DW-1:0]     x_ff, x_in;
   logic signed [DW-1:0]     y_ff, y_in;
   logic signed [Z_BITS-1:0] z_ff, z_in;
   logic [RANGE_BITS-1:0]    r_ff, r_in;
   spc_tag_type              tag_ff, tag_in;

   assign up_ready = !valid_ff || dn_ready;

   // arithmetic shifts round toward minus infinity
   assign dx = up_y >>> STAGE;
   assign dy = up_x >>> STAGE;

   always_comb begin
      valid_in = valid_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      r_in     = r_ff;
      tag_in   = tag_ff;
      if (up_ready) begin
         valid_in = up_valid;
         r_in     = up_r;
         tag_in   = up_tag;
         if (!up_z[Z_BITS-1]) begin
            x_in = up_x - dx;
            y_in = up_y + dy;
            z_in = up_z - TURN;
         end else begin
            x_in = up_x + dx;
            y_in = up_y - dy;
            z_in = up_z + TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      r_ff   <= r_in;
      tag_ff <= tag_in;
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_r     = r_ff;
   assign dn_tag   = tag_ff;

endmodule

// ===== hdl/spc_back.sv =====
// Back end: round to millimetres, saturate to the range, unfold and hold the result item.
`timescale 1ns / 1ps

module spc_back #(
   parameter int RANGE_BITS = 16,
   localparam int DW        = RANGE_BITS + 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic signed [DW-1:0]  up_x,
   input  logic signed [DW-1:0]  up_y,
   input  logic [RANGE_BITS-1:0] up_r,
   input  spc_pkg::spc_tag_type  up_tag,
   spc_rsp_if.source             rsp
);
   import spc_pkg::*;

   localparam int OW = RANGE_BITS + 2;
   localparam logic signed [DW-1:0] HALF = DW'(64'd1 << 29);

   // round Q30 to nearest, clip to [-lim, lim], negate for folded angles
   function automatic logic signed [OW-1:0] finish(input logic signed [DW-1:0] v,
                                                   input logic [RANGE_BITS-1:0] r,
                                                   input logic neg);
      logic signed [DW-1:0] sh;
      logic signed [OW-1:0] q;
      logic signed [OW-1:0] lim;
      sh  = (v + HALF) >>> 30;
      q   = sh[OW-1:0];
      lim = $signed({2'b00, r});
      if (q > lim) begin
         q = lim;
      end else if (q < -lim) begin
         q = -lim;
      end
      if (neg) begin
         q = -q;
      end
      return q;
   endfunction

   logic signed [OW-1:0]       xr, yr;
   logic                       valid_ff, valid_in;
   logic signed [POS_BITS-1:0] x_ff, x_in;
   logic signed [POS_BITS-1:0] y_ff, y_in;
   logic                       clamped_ff, clamped_in;
   logic                       index_error_ff, index_error_in;

   assign up_ready = !valid_ff || rsp.ready;
   assign xr       = finish(up_x, up_r, up_tag.flip);
   assign yr       = finish(up_y, up_r, up_tag.flip);

   always_comb begin
      valid_in       = valid_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      clamped_in     = clamped_ff;
      index_error_in = index_error_ff;
      if (up_ready) begin
         valid_in       = up_valid;
         index_error_in = up_tag.index_error;
         if (up_tag.index_error) begin
            // beam outside the scan: zero point, no clamp report
            x_in       = '0;
            y_in       = '0;
            clamped_in = 1'b0;
         end else begin
            x_in       = POS_BITS'(xr);
            y_in       = POS_BITS'(yr);
            clamped_in = up_tag.clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff           <= x_in;
      y_ff           <= y_in;
      clamped_ff     <= clamped_in;
      index_error_ff <= index_error_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.x_pos       = x_ff;
   assign rsp.y_pos       = y_ff;
   assign rsp.clamped     = clamped_ff;
   assign rsp.index_error = index_error_ff;

endmodule

// ===== hdl/scan_polar_to_cartesian.sv =====
// Path from an accepted item to its result: 2 front stages, 28 CORDIC cells, 1 output stage.
// Throughput: one item per cycle while results are taken, through the chain of 28 registered CORDIC rotation cells.
// Each stage holds its item while the next one is full and stalled; empty stages keep accepting items.
// Reset is synchronous: all valid bits clear and the registers return to start_angle 0,
// step_angle 0, num_steps 1, max_range 65535. Payload registers are not reset.
`timescale 1ns / 1ps

module scan_polar_to_cartesian #(
   parameter int MAX_BEAMS  = 2048,
   parameter int ANGLE_BITS = 16,
   parameter int RANGE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   spc_req_if.sink                           req,
   spc_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [spc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [spc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import spc_pkg::*;

   localparam int DW = RANGE_BITS + 32;
   localparam int N  = CORDIC_ITERS;

   spc_cfg_type cfg_ff, cfg_in;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (spc_csr_type'(csr_index))
            CSR_START_ANGLE: cfg_in.start_angle = csr_wdata;
            CSR_STEP_ANGLE:  cfg_in.step_angle  = csr_wdata;
            CSR_NUM_STEPS:   cfg_in.num_steps   = csr_wdata[11:0];
            CSR_MAX_RANGE:   cfg_in.max_range   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_angle <= 16'd0;
         cfg_ff.step_angle  <= 16'sd0;
         cfg_ff.num_steps   <= 12'd1;
         cfg_ff.max_range   <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // chain links: index k feeds cell k, index N feeds the back end
   logic                     valid_c [N+1];
   logic                     ready_c [N+1];
   logic signed [DW-1:0]     x_c     [N+1];
   logic signed [DW-1:0]     y_c     [N+1];
   logic signed [Z_BITS-1:0] z_c     [N+1];
   logic [RANGE_BITS-1:0]    r_c     [N+1];
   spc_tag_type              tag_c   [N+1];

   assign y_c[0] = '0;

   spc_front #(
      .MAX_BEAMS  (MAX_BEAMS),
      .ANGLE_BITS (ANGLE_BITS),
      .RANGE_BITS (RANGE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .up_valid     (req.valid),
      .up_ready     (req.ready),
      .beam_index   (req.beam_index),
      .range_sample (req.range_sample),
      .dn_valid     (valid_c[0]),
      .dn_ready     (ready_c[0]),
      .dn_x         (x_c[0]),
      .dn_z         (z_c[0]),
      .dn_r         (r_c[0]),
      .dn_tag       (tag_c[0])
   );

   for (genvar k = 0; k < N; k++) begin : g_cell
      spc_cell #(
         .STAGE      (k),
         .RANGE_BITS (RANGE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_c[k]),
         .up_ready (ready_c[k]),
         .up_x     (x_c[k]),
         .up_y     (y_c[k]),
         .up_z     (z_c[k]),
         .up_r     (r_c[k]),
         .up_tag   (tag_c[k]),
         .dn_valid (valid_c[k+1]),
         .dn_ready (ready_c[k+1]),
         .dn_x     (x_c[k+1]),
         .dn_y     (y_c[k+1]),
         .dn_z     (z_c[k+1]),
         .dn_r     (r_c[k+1]),
         .dn_tag   (tag_c[k+1])
      );
   end

   spc_back #(
      .RANGE_BITS (RANGE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_c[N]),
      .up_ready (ready_c[N]),
      .up_x     (x_c[N]),
      .up_y     (y_c[N]),
      .up_r     (r_c[N]),
      .up_tag   (tag_c[N]),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   // out-of-scan beams give a zero point and no clamp flag
   a_index_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.index_error |-> rsp.x_pos == '0 && rsp.y_pos == '0 && !rsp.clamped)
      else $error("index_error item with nonzero payload");

   // coordinates never exceed the clamped range
   a_within_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |->
         ($signed(18'(rsp.x_pos)) <= $signed({2'b00, cfg_ff.max_range})) &&
         ($signed(18'(rsp.x_pos)) >= -$signed({2'b00, cfg_ff.max_range})) &&
         ($signed(18'(rsp.y_pos)) <= $signed({2'b00, cfg_ff.max_range})) &&
         ($signed(18'(rsp.y_pos)) >= -$signed({2'b00, cfg_ff.max_range})))
      else $error("coordinate outside max_range");

   // with the output moving, the whole chain must be open to new items
   a_ready_when_flowing: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && !rsp.ready) |-> req.ready)
      else $error("input stalled while output is not back-pressured");

   // clamp report and index error are exclusive
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.clamped && rsp.index_error))
      else $error("clamped and index_error both set");
`endif

endmodule

// ===== dv/tb_scan_polar_to_cartesian.sv =====
// Self-checking testbench for the scan polar-to-Cartesian converter.
`timescale 1ns / 1ps

module tb_scan_polar_to_cartesian;
   import spc_pkg::*;

   localparam int  PIPE_LATENCY  = 31;
   localparam int  STALL_LIMIT   = 5000;
   localparam int  BEAM_LIMIT    = 2048;
   localparam int  RANDOM_PHASES = 16;
   localparam int  PHASE_ITEMS   = 106;
   localparam longint GAIN_Q30   = 64'sd652032874;

   // Register indexes with no register behind them
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLE_LO = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLE_HI = 3'd7;

   // atan(2^-i) in 2^32 units per turn
   localparam longint ROT_ANGLE [0:27] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
   };

   typedef struct {
      logic [BEAM_BITS-1:0]  beam_index;
      logic [RSAMP_BITS-1:0] range_sample;
   } sample_type;

   typedef struct {
      logic signed [POS_BITS-1:0] x_pos;
      logic signed [POS_BITS-1:0] y_pos;
      logic                       clamped;
      logic                       index_error;
   } point_type;

   logic clock;
   logic reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   spc_req_if req_if ();
   spc_rsp_if rsp_if ();

   scan_polar_to_cartesian dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Scan geometry as the block should hold it
   logic [15:0]        geo_start;
   logic signed [15:0] geo_step;
   logic [11:0]        geo_beams;
   logic [15:0]        geo_max_range;

   sample_type pending_samples [$];
   point_type  expected_points [$];

   int send_idle_pct;
   int recv_stall_pct;
   int fail_count;
   int items_in;
   int points_out;
   int index_errors_seen;
   int clamps_seen;
   int settings_seen;
   int quiet_cycles;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Effective beam count after the zero and upper limits
   function automatic int scan_beams();
      int beams;
      beams = int'(geo_beams);
      if (beams == 0) beams = 1;
      if (beams > BEAM_LIMIT) beams = BEAM_LIMIT;
      return beams;
   endfunction

   // Clamp, angle and gain-compensated CORDIC rotation of one sample
   function automatic point_type predict_point(input sample_type s);
      point_type  p;
      int         angle_sum;
      logic [15:0] r;
      logic [31:0] a32;
      logic        flip;
      longint      x, y, z, dx, dy, lim;
      p.x_pos = '0;
      p.y_pos = '0;
      p.clamped = 1'b0;
      p.index_error = 1'b0;
      if (int'(s.beam_index) >= scan_beams()) begin
         p.index_error = 1'b1;
         return p;
      end
      r = s.range_sample;
      if (r > geo_max_range) begin
         r = geo_max_range;
         p.clamped = 1'b1;
      end
      lim = longint'(r);
      angle_sum = int'(geo_start) + int'(s.beam_index) * int'(geo_step);
      a32 = {angle_sum[15:0], 16'h0000};
      // second and third quadrants: rotate by half a turn, negate at the end
      flip = a32[31] ^ a32[30];
      if (flip) a32[31] = ~a32[31];
      z = longint'(signed'(a32));
      x = lim * GAIN_Q30;
      y = 0;
      for (int i = 0; i < 28; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ROT_ANGLE[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ROT_ANGLE[i];
         end
      end
      x = (x + (64'sd1 <<< 29)) >>> 30;
      y = (y + (64'sd1 <<< 29)) >>> 30;
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      if (y > lim) y = lim;
      if (y < -lim) y = -lim;
      if (flip) begin
         x = -x;
         y = -y;
      end
      p.x_pos = x[POS_BITS-1:0];
      p.y_pos = y[POS_BITS-1:0];
      return p;
   endfunction

   // Driver: presents queued samples, holds an item until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_if.valid && req_if.ready) begin
            expected_points.push_back(predict_point(pending_samples[0]));
            if (expected_points[$].index_error) index_errors_seen++;
            if (expected_points[$].clamped) clamps_seen++;
            void'(pending_samples.pop_front());
            items_in++;
         end
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid        <= 1'b1;
            req_if.beam_index   <= pending_samples[0].beam_index;
            req_if.range_sample <= pending_samples[0].range_sample;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: every result against the oldest expected point
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         points_out++;
         if (expected_points.size() == 0) begin
            if (fail_count < 10)
               $display("[%0t] result with nothing pending: x=%0d y=%0d clamp=%b err=%b",
                        $realtime, rsp_if.x_pos, rsp_if.y_pos, rsp_if.clamped,
                        rsp_if.index_error);
            fail_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_if.x_pos !== want.x_pos || rsp_if.y_pos !== want.y_pos ||
                rsp_if.clamped !== want.clamped || rsp_if.index_error !== want.index_error)
            begin
               if (fail_count < 10)
                  $display("[%0t] exp x=%0d y=%0d cl=%b ie=%b, got x=%0d y=%0d cl=%b ie=%b",
                           $realtime, want.x_pos, want.y_pos, want.clamped,
                           want.index_error, rsp_if.x_pos, rsp_if.y_pos,
                           rsp_if.clamped, rsp_if.index_error);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // One register write; the write lands at the next edge
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_START_ANGLE: geo_start     = data;
         CSR_STEP_ANGLE:  geo_step      = data;
         CSR_NUM_STEPS:   geo_beams     = data[11:0];
         CSR_MAX_RANGE:   geo_max_range = data;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      settings_seen++;
   endtask

   task automatic program_scan(input logic [15:0] start, input logic [15:0] step,
                               input logic [15:0] beams, input logic [15:0] maxr);
      write_reg(CSR_START_ANGLE, start);
      write_reg(CSR_STEP_ANGLE, step);
      write_reg(CSR_NUM_STEPS, beams);
      write_reg(CSR_MAX_RANGE, maxr);
      end_writes();
   endtask

   // Pacing and queue changes happen on the falling edge
   task automatic set_pacing(input int mode);
      @(negedge clock);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
         default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
   endtask

   task automatic queue_sample(input int beam, input int rsamp);
      sample_type s;
      s.beam_index   = BEAM_BITS'(beam);
      s.range_sample = RSAMP_BITS'(rsamp);
      pending_samples.push_back(s);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending_samples.size() > 0 || expected_points.size() > 0);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   // Random scan geometry, extremes mixed in
   task automatic program_random_scan();
      logic [15:0] step, beams, maxr;
      case ($urandom_range(7))
         0: step = 16'h8000;
         1: step = 16'h7FFF;
         2: step = 16'($urandom_range(16)) - 16'd8;
         default: step = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0: beams = 16'd0;
         1: beams = 16'($urandom);
         2: beams = 16'd2048;
         3: beams = 16'($urandom_range(4095, 2049));
         4: beams = 16'($urandom_range(16, 1));
         default: beams = 16'($urandom_range(2048, 1));
      endcase
      case ($urandom_range(9))
         0: maxr = 16'd0;
         1: maxr = 16'hFFFF;
         default: maxr = 16'($urandom);
      endcase
      if ($urandom_range(3) == 0)
         write_reg(3'($urandom_range(CSR_HOLE_HI, CSR_HOLE_LO)), 16'($urandom));
      program_scan(16'($urandom), step, beams, maxr);
   endtask

   task automatic queue_random_samples(input int count);
      int beam, rsamp;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) beam = $urandom_range(BEAM_LIMIT - 1);
         else beam = $urandom_range(scan_beams() - 1);
         case ($urandom_range(9))
            0: rsamp = 0;
            1: rsamp = 65535;
            2, 3: rsamp = int'(geo_max_range) + $urandom_range(4) - 2;
            default: rsamp = $urandom_range(65535);
         endcase
         if (rsamp < 0) rsamp = 0;
         if (rsamp > 65535) rsamp = 65535;
         queue_sample(beam, rsamp);
      end
   endtask

   // Stimulus sequence
   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.beam_index   = '0;
      req_if.range_sample = '0;
      rsp_if.ready        = 1'b0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      fail_count          = 0;
      items_in            = 0;
      points_out          = 0;
      index_errors_seen   = 0;
      clamps_seen         = 0;
      settings_seen       = 1;
      geo_start           = 16'd0;
      geo_step            = 16'sd0;
      geo_beams           = 12'd1;
      geo_max_range       = 16'hFFFF;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: a single beam, out-of-scan indexes flagged
      set_pacing(0);
      queue_sample(0, 0);
      queue_sample(0, 65535);
      queue_sample(1, 100);
      queue_sample(2047, 65535);
      wait_drained();

      // Zero beam count, zero max range, writes to unused indexes
      write_reg(CSR_HOLE_LO, 16'h1234);
      write_reg(CSR_HOLE_HI, 16'hFFFF);
      program_scan(16'h4000, 16'h4000, 16'h0000, 16'h0000);
      set_pacing(3);
      queue_sample(0, 0);
      queue_sample(0, 1);
      queue_sample(1, 5);
      wait_drained();

      // Quarter-turn steps, beam count above the limit with high bits set
      program_scan(16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF);
      set_pacing(2);
      for (int b = 0; b < 5; b++) queue_sample(b, 65535);
      queue_sample(2047, 65535);
      wait_drained();

      // Most negative step, clamping around max range, quadrant edges
      program_scan(16'hFFFF, 16'h8000, 16'd2048, 16'd1000);
      set_pacing(1);
      queue_sample(0, 1001);
      queue_sample(1, 1000);
      queue_sample(2, 999);
      queue_sample(3, 65535);
      queue_sample(2047, 1);
      wait_drained();

      // Largest positive step, short scan
      program_scan(16'h2000, 16'h7FFF, 16'd3, 16'd40000);
      set_pacing(0);
      queue_sample(0, 40000);
      queue_sample(1, 65535);
      queue_sample(2, 12345);
      queue_sample(3, 500);
      wait_drained();

      // Random geometry, mostly in-scan samples
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         program_random_scan();
         set_pacing(ph);
         queue_random_samples(PHASE_ITEMS);
         wait_drained();
      end

      fail_count += expected_points.size();
      $display("Ran %0d items through %0d scan geometries under four pacing modes.",
               items_in, settings_seen);
      $display("Results checked: %0d, index errors: %0d, clamped samples: %0d.",
               points_out, index_errors_seen, clamps_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/spc_pkg.sv
hdl/spc_req_if.sv
hdl/spc_rsp_if.sv
hdl/spc_front.sv
hdl/spc_cell.sv
hdl/spc_back.sv
hdl/scan_polar_to_cartesian.sv
dv/tb_scan_polar_to_cartesian.sv
